// ----- rtl/ph_average_deadband_doser_core_assert.svh -----
// assertion macros for the rtl files; only the core file includes them
// both macros sample on clk and are disabled while rst_n is low
`ifndef PH_AVERAGE_DEADBAND_DOSER_CORE_ASSERT_SVH
`define PH_AVERAGE_DEADBAND_DOSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PHADB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PHADB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PHADB_ASSERT_IMP(lbl, ante, cons, msg)
`define PHADB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/phadb_pkg.sv -----
`timescale 1ns / 1ps
package phadb_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int SLOPE_W  = 20;
    localparam int OFFSET_W = 15;
    localparam int PH_W     = 16;
    localparam int WLEN_W   = 5;
    localparam int SETP_W   = 8;
    localparam int BAND_W   = 7;
    localparam int PULSE_W  = 4;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = SLOPE_W + SAMPLE_W;
    localparam int PH_MAX   = 65535;

    // tenths to hundredths
    localparam int TENTHS_SCALE = 10;
    localparam int EDGE_W       = 12;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE       = 3'd0,
        CFG_OFFSET_MAG  = 3'd1,
        CFG_OFFSET_NEG  = 3'd2,
        CFG_WINDOW      = 3'd3,
        CFG_SETPOINT    = 3'd4,
        CFG_DEADBAND    = 3'd5,
        CFG_PULSE       = 3'd6,
        CFG_ENABLE      = 3'd7
    } cfg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WIN,
        ST_DIV,
        ST_OUT
    } state_t;

    // status of a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ----- rtl/phadb_mul.sv -----
`timescale 1ns / 1ps
module phadb_mul
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [phadb_pkg::SAMPLE_W-1:0]        sample,
    input  logic signed [phadb_pkg::SLOPE_W-1:0]  slope,
    input  logic [phadb_pkg::OFFSET_W-1:0]        offset_mag,
    input  logic                                  offset_neg,
    output phadb_pkg::unit_stat_t                 stat,
    output logic [phadb_pkg::PH_W-1:0]            ph
);

    localparam int CNT_W = $clog2(phadb_pkg::SAMPLE_W);
    localparam int SUMV_W = phadb_pkg::SLOPE_W - phadb_pkg::SAMPLE_W + phadb_pkg::SAMPLE_W + 1;

    logic                                 busy_reg;
    logic                                 fin_reg;
    logic                                 done_reg;
    logic [CNT_W-1:0]                     cnt_reg;
    logic signed [phadb_pkg::PROD_W-1:0]  acc_reg;
    logic signed [phadb_pkg::PROD_W-1:0]  mcand_reg;
    logic [phadb_pkg::SAMPLE_W-1:0]       mplier_reg;
    logic [phadb_pkg::PH_W-1:0]           ph_reg;
    logic [phadb_pkg::PH_W-1:0]           ph_next;
    logic signed [phadb_pkg::SLOPE_W-1:0] quot;
    logic signed [SUMV_W-1:0]             value;
    logic signed [SUMV_W-1:0]             offset_ext;

    // floor shift, offset and clamp
    always_comb
    begin
        quot       = acc_reg[phadb_pkg::PROD_W-1:phadb_pkg::SAMPLE_W];
        offset_ext = $signed({{(SUMV_W - phadb_pkg::OFFSET_W){1'b0}}, offset_mag});
        if (offset_neg)
        begin
            value = SUMV_W'(quot) - offset_ext;
        end
        else
        begin
            value = SUMV_W'(quot) + offset_ext;
        end
        if (value < 0)
        begin
            ph_next = '0;
        end
        else if (value > SUMV_W'(phadb_pkg::PH_MAX))
        begin
            ph_next = phadb_pkg::PH_W'(phadb_pkg::PH_MAX);
        end
        else
        begin
            ph_next = value[phadb_pkg::PH_W-1:0];
        end
    end

    // control of the shift-add sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(phadb_pkg::SAMPLE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= phadb_pkg::PROD_W'(slope);
            mplier_reg <= sample;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (fin_reg)
        begin
            ph_reg <= ph_next;
        end
    end

    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;
    assign ph        = ph_reg;

endmodule

// ----- rtl/phadb_win.sv -----
`timescale 1ns / 1ps
module phadb_win
#(
    parameter int WINDOW_MAX = 16
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [phadb_pkg::PH_W-1:0]                   ph,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]              win,
    output phadb_pkg::unit_stat_t                        stat,
    output logic [phadb_pkg::PH_W+$clog2(WINDOW_MAX+1)-1:0] sum
);

    localparam int WIN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = phadb_pkg::PH_W + WIN_W;

    logic [phadb_pkg::PH_W-1:0] history_reg [WINDOW_MAX];
    logic [WIN_W-1:0]           slot_reg;
    logic [WIN_W-1:0]           slot_use;
    logic [WIN_W-1:0]           k_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;

    // slot wraps when it has run past the window
    assign slot_use = (slot_reg >= win) ? '0 : slot_reg;
    assign sum_next = sum_reg + SUM_W'(history_reg[k_reg[IDX_W-1:0]]);

    // ring store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                history_reg[i] <= '0;
            end
            slot_reg <= '0;
        end
        else if (start)
        begin
            history_reg[slot_use[IDX_W-1:0]] <= ph;
            slot_reg <= slot_use + 1'b1;
        end
    end

    // one entry added per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == win - 1'b1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= '0;
        end
        else if (busy_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign sum       = sum_reg;

endmodule

// ----- rtl/phadb_div.sv -----
`timescale 1ns / 1ps
module phadb_div
#(
    parameter int SUM_W = 21,
    parameter int WIN_W = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SUM_W-1:0]          dividend,
    input  logic [WIN_W-1:0]          divisor,
    output phadb_pkg::unit_stat_t     stat,
    output logic [phadb_pkg::PH_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [WIN_W-1:0] rem_reg;
    logic [WIN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIN_W:0]   trial;
    logic [WIN_W:0]   diff;

    // restoring step: one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= diff[WIN_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WIN_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg[phadb_pkg::PH_W-1:0];

endmodule

// ----- rtl/ph_average_deadband_doser_core.sv -----
// a request taken passes through multiply and clamp, window sum, divide and output load;
// the input stays closed until the result is loaded, so a new request is taken only after
// the bit-serial multiply, window sum and divide of the last one are through
// a finished result may wait in the output register while the next request is taken
// reset (rst_n, asynchronous, active low) clears ring, slot, phase and pump, loads defaults
`timescale 1ns / 1ps
`include "ph_average_deadband_doser_core_assert.svh"
module ph_average_deadband_doser_core
#(
    parameter int WINDOW_MAX = 16,
    parameter int PHASE_TOP  = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave request: [7:0] adc_sample
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    // master request: [15:0] ph_average, [16] dose_on
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [phadb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [phadb_pkg::CFG_W-1:0]         cfg_data
);

    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = phadb_pkg::PH_W + WIN_W;
    localparam int PHASE_W = $clog2(PHASE_TOP + 1);

    // configuration registers
    logic signed [phadb_pkg::SLOPE_W-1:0] slope_reg;
    logic [phadb_pkg::OFFSET_W-1:0]       offset_mag_reg;
    logic                                 offset_neg_reg;
    logic [phadb_pkg::WLEN_W-1:0]         window_reg;
    logic [phadb_pkg::SETP_W-1:0]         setpoint_reg;
    logic [phadb_pkg::BAND_W-1:0]         deadband_reg;
    logic [phadb_pkg::PULSE_W-1:0]        pulse_reg;
    logic                                 enable_reg;

    phadb_pkg::state_t                    state_reg;
    phadb_pkg::state_t                    state_next;
    logic [PHASE_W-1:0]                   phase_reg;
    logic [PHASE_W-1:0]                   phase_next;
    logic                                 pump_reg;
    logic                                 pump_next;
    logic                                 m_valid_reg;
    logic [phadb_pkg::PH_W-1:0]           m_avg_reg;
    logic                                 m_dose_reg;

    logic                                 in_accept;
    logic                                 mul_start;
    logic                                 win_start;
    logic                                 div_start;
    logic                                 out_load;
    logic [WIN_W-1:0]                     win_eff;
    logic [phadb_pkg::PH_W-1:0]           ph_val;
    logic [SUM_W-1:0]                     win_sum;
    logic [phadb_pkg::PH_W-1:0]           avg;
    logic [phadb_pkg::EDGE_W-1:0]         sp_hund;
    logic [phadb_pkg::EDGE_W-1:0]         db_hund;
    logic                                 below;
    logic                                 unit_busy;
    phadb_pkg::unit_stat_t                mul_st;
    phadb_pkg::unit_stat_t                win_st;
    phadb_pkg::unit_stat_t                div_st;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg      <= '0;
            offset_mag_reg <= '0;
            offset_neg_reg <= 1'b0;
            window_reg     <= phadb_pkg::WLEN_W'(6);
            setpoint_reg   <= phadb_pkg::SETP_W'(70);
            deadband_reg   <= '0;
            pulse_reg      <= phadb_pkg::PULSE_W'(3);
            enable_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (phadb_pkg::cfg_index_t'(cfg_index))
                phadb_pkg::CFG_SLOPE:      slope_reg      <= $signed(cfg_data);
                phadb_pkg::CFG_OFFSET_MAG: offset_mag_reg <= cfg_data[phadb_pkg::OFFSET_W-1:0];
                phadb_pkg::CFG_OFFSET_NEG: offset_neg_reg <= cfg_data[0];
                phadb_pkg::CFG_WINDOW:     window_reg     <= cfg_data[phadb_pkg::WLEN_W-1:0];
                phadb_pkg::CFG_SETPOINT:   setpoint_reg   <= cfg_data[phadb_pkg::SETP_W-1:0];
                phadb_pkg::CFG_DEADBAND:   deadband_reg   <= cfg_data[phadb_pkg::BAND_W-1:0];
                phadb_pkg::CFG_PULSE:      pulse_reg      <= cfg_data[phadb_pkg::PULSE_W-1:0];
                phadb_pkg::CFG_ENABLE:     enable_reg     <= cfg_data[0];
            endcase
        end
    end

    // effective window: zero means one, long windows saturate
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (32'(window_reg) > WINDOW_MAX)
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = WIN_W'(window_reg);
        end
    end

    // serial units
    phadb_mul u_mul
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start),
        .sample     (s_tdata),
        .slope      (slope_reg),
        .offset_mag (offset_mag_reg),
        .offset_neg (offset_neg_reg),
        .stat       (mul_st),
        .ph         (ph_val)
    );

    phadb_win #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_win (
        .clk   (clk),
        .rst_n (rst_n),
        .start (win_start),
        .ph    (ph_val),
        .win   (win_eff),
        .stat  (win_st),
        .sum   (win_sum)
    );

    phadb_div #(
        .SUM_W (SUM_W),
        .WIN_W (WIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (win_sum),
        .divisor  (win_eff),
        .stat     (div_st),
        .quotient (avg)
    );

    // phase advance and deadband decision
    always_comb
    begin
        if (phase_reg == PHASE_W'(PHASE_TOP))
        begin
            phase_next = '0;
        end
        else
        begin
            phase_next = phase_reg + 1'b1;
        end
        sp_hund = phadb_pkg::EDGE_W'(32'(setpoint_reg) * phadb_pkg::TENTHS_SCALE);
        db_hund = phadb_pkg::EDGE_W'(32'(deadband_reg) * phadb_pkg::TENTHS_SCALE);
        below   = (sp_hund > db_hund) && (32'(avg) < 32'(sp_hund - db_hund));
        if (enable_reg)
        begin
            pump_next = below && (32'(phase_next) < 32'(pulse_reg));
        end
        else
        begin
            pump_next = pump_reg;
        end
    end

    // sequencer
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == phadb_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        win_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            phadb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mul_start  = 1'b1;
                    state_next = phadb_pkg::ST_MUL;
                end
            end
            phadb_pkg::ST_MUL:
            begin
                if (mul_st.done)
                begin
                    win_start  = 1'b1;
                    state_next = phadb_pkg::ST_WIN;
                end
            end
            phadb_pkg::ST_WIN:
            begin
                if (win_st.done)
                begin
                    div_start  = 1'b1;
                    state_next = phadb_pkg::ST_DIV;
                end
            end
            phadb_pkg::ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = phadb_pkg::ST_OUT;
                end
            end
            phadb_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = phadb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = phadb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= phadb_pkg::ST_IDLE;
            phase_reg   <= '0;
            pump_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                phase_reg   <= phase_next;
                pump_reg    <= pump_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_avg_reg  <= avg;
            m_dose_reg <= pump_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_dose_reg, m_avg_reg};

    // checks
    assign unit_busy = mul_st.busy | win_st.busy | div_st.busy;

    `PHADB_ASSERT_NXT(a_accept_mul, in_accept, mul_st.busy, "multiply idle after a request")
    `PHADB_ASSERT_IMP(a_idle_quiet, s_tready, !unit_busy, "serial unit busy while idle")
    `PHADB_ASSERT_IMP(a_div_done, div_st.done, state_reg == phadb_pkg::ST_DIV, "late divide")
    `PHADB_ASSERT_IMP(a_phase_range, 1'b1, 32'(phase_reg) <= PHASE_TOP, "phase past its top")

endmodule
